[design/tms_pkg.sv]
// ----------------------------------------------------------------------------
// tms_pkg
// Shared types and constants of the thermostat mode sequencer.
// ----------------------------------------------------------------------------
package tms_pkg;

	localparam int MAX_SLOTS  = 8;
	localparam int SLOT_IDX_W = 3;
	localparam int SLOT_CNT_W = 4;
	localparam int MIN_W      = 11;
	localparam int TEMP_W     = 9;
	localparam int TICK_W     = 32;
	localparam int IN_DATA_W  = 120;
	localparam int OUT_DATA_W = 40;
	localparam int CFG_W      = 32;
	localparam int CFG_IDX_W  = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_TEMP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BOOST_TICKS = 2'd2;

	localparam logic [SLOT_CNT_W-1:0] SLOT_COUNT_RST  = 4'd0;
	localparam logic [TEMP_W-1:0]     MANUAL_TEMP_RST = 9'd200;
	localparam logic [TICK_W-1:0]     BOOST_TICKS_RST = 32'd300000;

	// thermostat states
	localparam logic [2:0] ST_INIT      = 3'd0;
	localparam logic [2:0] ST_DATETIME  = 3'd1;
	localparam logic [2:0] ST_SCHEDULE  = 3'd2;
	localparam logic [2:0] ST_NOTINST   = 3'd3;
	localparam logic [2:0] ST_ADAPT     = 3'd4;
	localparam logic [2:0] ST_ADAPTFAIL = 3'd5;
	localparam logic [2:0] ST_RUNNING   = 3'd6;
	localparam logic [2:0] ST_FACTORY   = 3'd7;

	// item kinds
	localparam logic [2:0] ACT_TICK    = 3'd0;
	localparam logic [2:0] ACT_STORAGE = 3'd1;
	localparam logic [2:0] ACT_USER    = 3'd2;
	localparam logic [2:0] ACT_MAINT   = 3'd3;
	localparam logic [2:0] ACT_LOAD    = 3'd4;

	// event codes
	localparam logic [2:0] EV_LOAD_END    = 3'd0;
	localparam logic [2:0] EV_RESET_END   = 3'd1;
	localparam logic [2:0] EV_DT_DONE     = 3'd0;
	localparam logic [2:0] EV_SCHED_DONE  = 3'd1;
	localparam logic [2:0] EV_INSTALL     = 3'd2;
	localparam logic [2:0] EV_ADAPT_RETRY = 3'd3;
	localparam logic [2:0] EV_FACTORY     = 3'd4;
	localparam logic [2:0] EV_MAINT_OK    = 3'd0;
	localparam logic [2:0] EV_MAINT_FAIL  = 3'd1;

	// heating modes
	localparam logic [1:0] HM_SCHEDULE = 2'd0;
	localparam logic [1:0] HM_FIXED    = 2'd1;
	localparam logic [1:0] HM_RAPID    = 2'd2;

	// adaptation result writes
	localparam logic [1:0] AR_NONE = 2'd0;
	localparam logic [1:0] AR_OK   = 2'd1;
	localparam logic [1:0] AR_FAIL = 2'd2;

	localparam logic [TEMP_W-1:0] TEMP_DEFAULT = 9'd200;
	localparam logic [TEMP_W-1:0] TEMP_BOOST   = 9'd300;
	localparam logic [MIN_W-1:0]  NO_SLOT      = 11'd2047;

	typedef struct packed {
		logic [2:0]            pad;
		logic [TEMP_W-1:0]     slot_temp;
		logic [MIN_W-1:0]      slot_end_minutes;
		logic [MIN_W-1:0]      slot_start_minutes;
		logic [SLOT_IDX_W-1:0] slot_index;
		logic                  override_active;
		logic [TICK_W-1:0]     boost_start;
		logic [1:0]            prior_mode;
		logic [1:0]            heat_mode;
		logic [TICK_W-1:0]     now_tick;
		logic [MIN_W-1:0]      day_minutes;
		logic [2:0]            event_code;
	} in_data_t;

	typedef struct packed {
		logic [5:0]        pad;
		logic              request_system_reset;
		logic              request_config_reset;
		logic              start_adapt;
		logic              notify_init_done;
		logic [1:0]        adapt_result_write;
		logic              clear_override;
		logic              slot_update;
		logic [MIN_W-1:0]  end_minutes_out;
		logic              target_valid;
		logic [TEMP_W-1:0] setpoint;
		logic [1:0]        mode_out;
		logic [2:0]        fsm_state_out;
	} out_data_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic scan_busy;
		logic out_free;
	} sts_t;

endpackage

[design/thermostat_mode_sequencer.sv]
// ----------------------------------------------------------------------------
// thermostat_mode_sequencer
// Radiator thermostat mode sequencer: state transitions, boost expiry,
// schedule slot lookup and target selection, one result per item.
// ----------------------------------------------------------------------------
// Every item gives exactly one result. It is loaded in idle, then passes the
// evaluate, scan and emit states; emit waits while an untaken result is held.
// For a running-state tick in auto mode, a single compare unit walks the slot
// store one entry a cycle, up to the saturated slot count (at most eight),
// until the first slot that holds the time of day. The next item is accepted
// as soon as the result is in the output register, even while it waits to be
// taken. Configuration must be written while idle; the block does not check.
module thermostat_mode_sequencer import tms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// event_code, day_minutes, now_tick, heat_mode, prior_mode, boost_start,
	// override_active, slot_index, slot_start_minutes, slot_end_minutes, slot_temp
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// action
	input  logic [2:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// fsm_state_out, mode_out, setpoint, target_valid, end_minutes_out,
	// slot_update, clear_override, adapt_result_write, notify_init_done,
	// start_adapt, request_config_reset, request_system_reset
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	tms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tms_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

endmodule

[design/tms_ctrl.sv]
// ----------------------------------------------------------------------------
// tms_ctrl
// Sequencing controller: takes an item, evaluates boost, walks the schedule
// slots and hands the result to the output register.
// ----------------------------------------------------------------------------
module tms_ctrl import tms_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [1:0] C_IDLE = 2'd0;
	localparam logic [1:0] C_EVAL = 2'd1;
	localparam logic [1:0] C_SCAN = 2'd2;
	localparam logic [1:0] C_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			C_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = C_EVAL;
				end
			end
			C_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = C_SCAN;
			end
			C_SCAN: begin
				if (sts.scan_busy) begin
					cmd.step = 1'b1;
				end else begin
					state_d = C_EMIT;
				end
			end
			C_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = C_IDLE;
				end
			end
			default: begin
				state_d = C_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[design/tms_datapath.sv]
// ----------------------------------------------------------------------------
// tms_datapath
// Item registers, schedule slot store, slot compare unit, thermostat state,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module tms_datapath import tms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [2:0]            s_tuser,
	input  logic                  m_tready,
	output logic                  m_tvalid,
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_wdata
);

	in_data_t in_d;
	assign in_d = in_data_t'(s_tdata);

	// configuration
	logic [SLOT_CNT_W-1:0] slot_count_q;
	logic [TEMP_W-1:0]     manual_temp_q;
	logic [TICK_W-1:0]     boost_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q  <= SLOT_COUNT_RST;
			manual_temp_q <= MANUAL_TEMP_RST;
			boost_ticks_q <= BOOST_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SLOT_COUNT:  slot_count_q  <= cfg_wdata[SLOT_CNT_W-1:0];
				CFG_MANUAL_TEMP: manual_temp_q <= cfg_wdata[TEMP_W-1:0];
				CFG_BOOST_TICKS: boost_ticks_q <= cfg_wdata[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// item registers
	logic [2:0]        action_q;
	logic [2:0]        code_q;
	logic [MIN_W-1:0]  mins_q;
	logic [TICK_W-1:0] now_q;
	logic [1:0]        mode_q;
	logic [1:0]        prior_q;
	logic [TICK_W-1:0] bstart_q;
	logic              ovr_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= s_tuser;
			code_q   <= in_d.event_code;
			mins_q   <= in_d.day_minutes;
			now_q    <= in_d.now_tick;
			mode_q   <= in_d.heat_mode;
			prior_q  <= in_d.prior_mode;
			bstart_q <= in_d.boost_start;
			ovr_q    <= in_d.override_active;
		end
	end

	// schedule slot store
	logic [MIN_W-1:0]  slot_starts [MAX_SLOTS];
	logic [MIN_W-1:0]  slot_ends   [MAX_SLOTS];
	logic [TEMP_W-1:0] slot_temps  [MAX_SLOTS];

	always_ff @(posedge clk) begin
		if (cmd.load && s_tuser == ACT_LOAD &&
		    SLOT_CNT_W'(in_d.slot_index) < SLOT_CNT_W'(MAX_SLOTS)) begin
			slot_starts[in_d.slot_index] <= in_d.slot_start_minutes;
			slot_ends[in_d.slot_index]   <= in_d.slot_end_minutes;
			slot_temps[in_d.slot_index]  <= in_d.slot_temp;
		end
	end

	// thermostat state
	logic [2:0]       fsm_q;
	logic [MIN_W-1:0] last_slot_end_q;

	// boost check and scan setup
	logic                  running_q;
	logic [1:0]            mode_eff_q;
	logic [SLOT_CNT_W-1:0] slot_n_q;
	logic [SLOT_CNT_W-1:0] idx_q;
	logic                  hit_q;
	logic [TEMP_W-1:0]     tgt_q;
	logic [MIN_W-1:0]      endm_q;
	logic [TICK_W-1:0]     elapsed;
	logic                  running_tick;
	logic                  auto_run;
	logic [MIN_W-1:0]      cur_start;
	logic [MIN_W-1:0]      cur_end;
	logic                  slot_match;

	assign elapsed      = now_q - bstart_q;
	assign running_tick = (action_q == ACT_TICK) && (fsm_q == ST_RUNNING);
	assign auto_run     = running_q && (mode_eff_q == HM_SCHEDULE);
	assign cur_start    = slot_starts[idx_q[SLOT_IDX_W-1:0]];
	assign cur_end      = slot_ends[idx_q[SLOT_IDX_W-1:0]];
	assign slot_match   = (mins_q >= cur_start) && (mins_q < cur_end);

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			running_q <= running_tick;
			if (running_tick && mode_q == HM_RAPID && elapsed >= boost_ticks_q) begin
				mode_eff_q <= prior_q;
			end else begin
				mode_eff_q <= mode_q;
			end
			slot_n_q <= (slot_count_q > SLOT_CNT_W'(MAX_SLOTS)) ?
			            SLOT_CNT_W'(MAX_SLOTS) : slot_count_q;
			idx_q    <= '0;
			hit_q    <= 1'b0;
		end else if (cmd.step) begin
			idx_q <= idx_q + SLOT_CNT_W'(1);
			if (slot_match) begin
				hit_q  <= 1'b1;
				tgt_q  <= slot_temps[idx_q[SLOT_IDX_W-1:0]];
				endm_q <= cur_end;
			end
		end
	end

	assign sts.scan_busy = auto_run && !hit_q && (idx_q < slot_n_q);

	// result assembly
	logic [2:0]  nxt;
	logic        sys_rst;
	out_data_t   res;
	logic        out_valid_q;
	out_data_t   out_q;

	always_comb begin
		nxt     = fsm_q;
		sys_rst = 1'b0;
		case (fsm_q)
			ST_INIT: begin
				if (action_q == ACT_STORAGE && code_q == EV_LOAD_END) nxt = ST_DATETIME;
			end
			ST_DATETIME: begin
				if (action_q == ACT_USER && code_q == EV_DT_DONE) nxt = ST_SCHEDULE;
			end
			ST_SCHEDULE: begin
				if (action_q == ACT_USER && code_q == EV_SCHED_DONE) nxt = ST_NOTINST;
			end
			ST_NOTINST: begin
				if (action_q == ACT_USER && code_q == EV_INSTALL) nxt = ST_ADAPT;
			end
			ST_ADAPT: begin
				if (action_q == ACT_MAINT && code_q == EV_MAINT_OK) nxt = ST_RUNNING;
				else if (action_q == ACT_MAINT && code_q == EV_MAINT_FAIL) nxt = ST_ADAPTFAIL;
			end
			ST_ADAPTFAIL: begin
				if (action_q == ACT_USER && code_q == EV_ADAPT_RETRY) nxt = ST_NOTINST;
			end
			ST_RUNNING: begin
				if (action_q == ACT_USER && code_q == EV_FACTORY) nxt = ST_FACTORY;
			end
			ST_FACTORY: begin
				if (action_q == ACT_STORAGE && code_q == EV_RESET_END) sys_rst = 1'b1;
			end
			default: begin
				nxt = fsm_q;
			end
		endcase
	end

	always_comb begin
		res                      = '0;
		res.fsm_state_out        = nxt;
		res.mode_out             = mode_eff_q;
		res.request_system_reset = sys_rst;
		if (running_q) begin
			case (mode_eff_q)
				HM_SCHEDULE: begin
					res.setpoint        = hit_q ? tgt_q : TEMP_DEFAULT;
					res.end_minutes_out = hit_q ? endm_q : '0;
					res.target_valid    = 1'b1;
					res.slot_update     = 1'b1;
					res.clear_override  = ovr_q && (res.end_minutes_out != last_slot_end_q);
				end
				HM_FIXED: begin
					res.setpoint     = manual_temp_q;
					res.target_valid = 1'b1;
				end
				HM_RAPID: begin
					res.setpoint     = TEMP_BOOST;
					res.target_valid = 1'b1;
				end
				default: begin
				end
			endcase
		end
		if (nxt != fsm_q) begin
			res.notify_init_done     = (fsm_q == ST_INIT);
			res.start_adapt          = (nxt == ST_ADAPT);
			res.request_config_reset = (nxt == ST_FACTORY);
			case (nxt)
				ST_ADAPTFAIL: res.adapt_result_write = AR_FAIL;
				ST_RUNNING:   res.adapt_result_write = AR_OK;
				default:      res.adapt_result_write = AR_NONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q           <= ST_INIT;
			last_slot_end_q <= NO_SLOT;
			out_valid_q     <= 1'b0;
		end else begin
			if (cmd.emit) begin
				fsm_q       <= nxt;
				out_valid_q <= 1'b1;
				if (auto_run) begin
					last_slot_end_q <= res.end_minutes_out;
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= res;
		end
	end

	assign sts.out_free = !out_valid_q || m_tready;
	assign m_tvalid     = out_valid_q;
	assign m_tdata      = OUT_DATA_W'(out_q);

endmodule
